FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/bffpa_pkg.sv
package bffpa_pkg;

  // Request codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_FREED   = 2'd1,
    ST_OOM     = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_PAGES = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_CLEAR,
    S_DONE
  } state_e;

endpackage

FILE: hdl/bitmap_first_fit_page_allocator.sv
// Bitmap first-fit page allocator. The used map sits in a one-bit-wide
// synchronous memory of MAX_PAGES entries, swept one page per cycle. An
// allocate request scans the map from page 0 until a run of free pages fits,
// then marks the granted pages; when no run fits it scans to the end of the
// region. The map read is registered. A free request clears its pages, up to
// the end of the region. Ignored requests, frees that start outside the region
// and allocations larger than the region go straight to the result. A new
// request is taken only once the last result has been taken. The map is
// cleared at reset by a pass over all MAX_PAGES entries, during which no
// request is taken. Configuration writes are taken at any time the block idles.
module bitmap_first_fit_page_allocator #(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] size_bytes_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_address_o,
  output logic [1:0]  status_o,
  output logic [10:0] free_page_total_o
);
  import bffpa_pkg::*;

  localparam int AW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int PW = 33 - PAGE_SHIFT;

  state_e            state_q, state_d;
  logic [31:0]       base_q;
  logic [10:0]       pcount_q;
  logic [CW-1:0]     free_q;
  logic              clr_q;
  logic [AW:0]       clr_idx_q;
  logic [CW-1:0]     limit;
  logic [PW-1:0]     need;
  logic [PW-1:0]     need_q;
  logic [CW:0]       idx_q, start_q, end_q;
  logic [PW-1:0]     run_q;
  logic              rd_pend_q;
  logic              mem_q [MAX_PAGES];
  logic              rd_q;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              wdata;
  logic [31:0]       offset;
  logic [31:0]       start_pg;
  logic [31:0]       res_addr_q;
  logic [1:0]        status_q;
  logic              ov_q;

  // Effective page count and page-rounded request size.
  assign limit = (32'(pcount_q) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pcount_q);
  assign need  = PW'(({1'b0, size_bytes_i} + 33'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT);
  assign offset   = address_i - base_q;
  assign start_pg = offset >> PAGE_SHIFT;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pcount_q <= 11'd1024;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BASE) base_q <= cfg_wdata_i;
      else pcount_q <= cfg_wdata_i[10:0];
    end
  end

  assign in_stall_o  = clr_q || (state_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign result_address_o  = res_addr_q;
  assign status_o          = status_q;
  assign free_page_total_o = 11'(free_q);

  // Memory write port.
  always_comb begin
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = 1'b0;
    if (clr_q) begin
      we = 1'b1;
      waddr = clr_idx_q[AW-1:0];
    end else if (state_q == S_MARK) begin
      we = 1'b1;
      wdata = 1'b1;
    end else if (state_q == S_CLEAR && idx_q < end_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i && !in_stall_o) begin
        if (size_bytes_i == 0) state_d = S_DONE;
        else if (func_i == FUNC_ALLOC)
          state_d = ({{(CW+1){1'b0}}, need} <= (PW+CW+1)'(limit)) ? S_SCAN : S_DONE;
        else if (address_i == 0 || start_pg >= 32'(limit)) state_d = S_DONE;
        else state_d = S_CLEAR;
      end
      S_SCAN: if (rd_pend_q) begin
        if (!rd_q && (run_q + 1'b1) == need_q) state_d = S_MARK;
        else if (idx_q >= (CW+1)'(limit)) state_d = S_DONE;
      end
      S_MARK:  if (idx_q + 1'b1 == end_q) state_d = S_DONE;
      S_CLEAR: if (idx_q + 1'b1 >= end_q) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      clr_q <= 1'b1;
      clr_idx_q <= '0;
      free_q <= CW'(MAX_PAGES);
      ov_q <= 1'b0;
      idx_q <= '0;
      rd_pend_q <= 1'b0;
      run_q <= '0;
      start_q <= '0;
      end_q <= '0;
      need_q <= '0;
      res_addr_q <= '0;
      status_q <= ST_IGNORED;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == (AW+1)'(MAX_PAGES - 1)) clr_q <= 1'b0;
      end
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && !in_stall_o) begin
          res_addr_q <= '0;
          status_q <= ST_IGNORED;
          idx_q <= '0;
          rd_pend_q <= 1'b0;
          run_q <= '0;
          need_q <= need;
          if (size_bytes_i != 0 && func_i == FUNC_ALLOC) status_q <= ST_OOM;
          if (size_bytes_i != 0 && func_i == FUNC_FREE && address_i != 0 &&
              start_pg < 32'(limit)) begin
            idx_q <= (CW+1)'(start_pg);
            if ({{(CW+1){1'b0}}, need} + (PW+CW+1)'(start_pg) > (PW+CW+1)'(limit))
              end_q <= (CW+1)'(limit);
            else
              end_q <= (CW+1)'(start_pg + 32'(need));
            status_q <= ST_FREED;
          end
        end
        S_SCAN: begin
          // Read issued for idx_q; data arrives in the following cycle.
          rd_pend_q <= 1'b1;
          if (rd_pend_q) begin
            if (!rd_q) begin
              if (run_q == 0) start_q <= idx_q - 1'b1;
              run_q <= run_q + 1'b1;
              if (run_q + 1'b1 == need_q) begin
                idx_q <= (run_q == 0) ? idx_q - 1'b1 : start_q;
                end_q <= idx_q;
                res_addr_q <= base_q + (32'((run_q == 0) ? idx_q - 1'b1 : start_q)
                              << PAGE_SHIFT);
                status_q <= ST_ALLOC;
              end else idx_q <= idx_q + 1'b1;
            end else begin
              run_q <= '0;
              idx_q <= idx_q + 1'b1;
            end
          end else idx_q <= idx_q + 1'b1;
        end
        S_MARK: begin
          idx_q <= idx_q + 1'b1;
          if (free_q != 0) free_q <= free_q - 1'b1;
        end
        S_CLEAR: begin
          if (idx_q < end_q) begin
            idx_q <= idx_q + 1'b1;
            if (free_q < CW'(MAX_PAGES)) free_q <= free_q + 1'b1;
          end
        end
        S_DONE: ov_q <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/bffpa_checker.sv
`include "assert_macros.svh"

// Port-level checks on the allocator.
module bffpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] result_address_o,
  input logic [10:0] free_page_total_o
);
  import bffpa_pkg::*;

  // No new request is taken while a result is pending.
  `ASSERT_IMPL(a_no_take_pending, clk_i, rst_ni, out_valid_o, in_stall_o)
  // A stalled result holds.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable({result_address_o, status_o, free_page_total_o}))
  // Non-grant results carry a zero address.
  `ASSERT_IMPL(a_zero_addr, clk_i, rst_ni, out_valid_o && status_o != ST_ALLOC, result_address_o == 32'd0)
  // An accepted request is followed by a busy cycle.
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind bitmap_first_fit_page_allocator bffpa_checker u_chk (.*);
